// File: design/kqt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kqt_pkg: shared definitions for the keyed quantity table
// Field widths, request and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package kqt_pkg;

  localparam int TABLE_DEPTH_DEF = 128;

  localparam int KEY_W      = 32;
  localparam int QTY_W      = 32;
  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int SLOT_W     = 7;
  localparam int USED_W     = 8;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_PAD_W  = OUT_DATA_W - STATUS_W - SLOT_W - QTY_W - USED_W;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ADD,
    S_RESP
  } state_t;

endpackage : kqt_pkg
`default_nettype wire

// File: design/keyed_quantity_table.sv
`default_nettype none
// Sequence: a scan reads one filled entry per cycle until a key match or the end of the filled
// entries, and an update hit then adds and writes back in S_ADD. A full-table insert or the
// unused code goes straight to S_RESP, where the result is loaded into the output register.
// Throughput: one transaction at a time; the next can be accepted in the cycle after the result
// is loaded, and a stalled output holds the block in S_RESP until the result is loaded.
// Reset clears the sequencer, the fill count and out_tvalid; table memories are not cleared.
// ----------------------------------------------------------------------------
// keyed_quantity_table
// Key/quantity table with append insert, linear-scan search and saturating update.
// ----------------------------------------------------------------------------
module keyed_quantity_table
  import kqt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] part_key, [63:32] amount
  input  wire logic [REQ_W-1:0]      in_tuser,   // [1:0] req_type
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // [1:0] status, [8:2] slot,
                                                 // [40:9] quantity, [48:41] entries_used
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  state_t state_r, state_nxt;

  logic [REQ_W-1:0]        req_r, req_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [QTY_W-1:0] amt_r, amt_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic [CNT_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                    cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic [KEY_W-1:0]        rd_key_r;
  logic signed [QTY_W-1:0] rd_qty_r;
  logic [STATUS_W-1:0]     res_status_r, res_status_nxt;
  logic [IDX_W-1:0]        res_slot_r, res_slot_nxt;
  logic signed [QTY_W-1:0] res_qty_r, res_qty_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;

  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [QTY_W-1:0] qty_mem [TABLE_DEPTH];

  logic                    rd_en;
  logic                    key_wr_en;
  logic                    qty_wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [QTY_W-1:0]        wr_qty;
  logic                    accept;
  logic                    is_full;
  logic                    hit;
  logic                    scan_done;
  logic                    out_load;
  logic signed [QTY_W:0]   sum;
  logic signed [QTY_W-1:0] sat_qty;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign is_full   = (fill_r == CNT_W'(TABLE_DEPTH));
  assign hit       = cmp_vld_r && (rd_key_r == key_r);
  // All filled entries issued and the last compare has drained.
  assign scan_done = !cmp_vld_r && (rd_idx_r >= fill_r);
  assign out_load  = (state_r == S_RESP) && (!out_valid_r || out_tready);

  // Saturating add: overflow shows as the two top bits of the 33-bit sum differing.
  assign sum = {rd_qty_r[QTY_W-1], rd_qty_r} + {amt_r[QTY_W-1], amt_r};
  always_comb begin
    if (sum[QTY_W] != sum[QTY_W-1]) begin
      sat_qty = sum[QTY_W] ? {1'b1, {(QTY_W-1){1'b0}}} : {1'b0, {(QTY_W-1){1'b1}}};
    end else begin
      sat_qty = sum[QTY_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_tuser == REQ_INSERT && is_full) begin
            state_nxt = S_RESP;
          end else if (in_tuser == REQ_INSERT || in_tuser == REQ_SEARCH ||
                       in_tuser == REQ_UPDATE) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = (req_r == REQ_UPDATE) ? S_ADD : S_RESP;
        end else if (scan_done) begin
          state_nxt = S_RESP;
        end
      end
      S_ADD: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    req_nxt        = req_r;
    key_nxt        = key_r;
    amt_nxt        = amt_r;
    fill_nxt       = fill_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_qty_nxt    = res_qty_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    rd_en          = 1'b0;
    key_wr_en      = 1'b0;
    qty_wr_en      = 1'b0;
    wr_addr        = cmp_idx_r;
    wr_qty         = sat_qty;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt        = in_tuser;
          key_nxt        = in_tdata[KEY_W-1:0];
          amt_nxt        = in_tdata[KEY_W +: QTY_W];
          rd_idx_nxt     = '0;
          res_status_nxt = (in_tuser == REQ_INSERT && is_full) ? ST_FULL : ST_OK;
          res_slot_nxt   = '0;
          res_qty_nxt    = '0;
        end
      end
      S_SCAN: begin
        rd_en       = (rd_idx_r < fill_r) && !hit;
        cmp_vld_nxt = rd_en;
        if (rd_en) begin
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
          cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
        end
        if (hit) begin
          unique case (req_r)
            REQ_INSERT: res_status_nxt = ST_EXISTS;
            REQ_SEARCH: begin
              res_status_nxt = ST_OK;
              res_slot_nxt   = cmp_idx_r;
              res_qty_nxt    = rd_qty_r;
            end
            default: ;
          endcase
        end else if (scan_done) begin
          if (req_r == REQ_INSERT) begin
            key_wr_en      = 1'b1;
            qty_wr_en      = 1'b1;
            wr_addr        = fill_r[IDX_W-1:0];
            wr_qty         = amt_r;
            fill_nxt       = fill_r + CNT_W'(1);
            res_status_nxt = ST_OK;
            res_slot_nxt   = fill_r[IDX_W-1:0];
            res_qty_nxt    = amt_r;
          end else begin
            res_status_nxt = ST_MISSING;
          end
        end
      end
      S_ADD: begin
        qty_wr_en      = 1'b1;
        res_status_nxt = ST_OK;
        res_slot_nxt   = cmp_idx_r;
        res_qty_nxt    = sat_qty;
      end
      S_RESP: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{OUT_PAD_W{1'b0}}, USED_W'(fill_r), res_qty_r,
                           SLOT_W'(res_slot_r), res_status_r};
        end
      end
      default: ;
    endcase
  end

  // Table storage, one read and one write port each
  always_ff @(posedge clk) begin
    if (key_wr_en) begin
      key_mem[wr_addr] <= key_r;
    end
    if (rd_en) begin
      rd_key_r <= key_mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (qty_wr_en) begin
      qty_mem[wr_addr] <= wr_qty;
    end
    if (rd_en) begin
      rd_qty_r <= qty_mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    amt_r        <= amt_nxt;
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_qty_r    <= res_qty_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule : keyed_quantity_table
`default_nettype wire

// File: design/kqt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kqt_checker: port-level checks for the keyed quantity table
// Watches both stream channels and the result fields over time.
// ----------------------------------------------------------------------------
module kqt_checker
  import kqt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [IN_DATA_W-1:0]  in_tdata,
  input wire logic [REQ_W-1:0]      in_tuser,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [QTY_W-1:0]    quantity;
  logic [USED_W-1:0]   entries_used;

  assign status       = out_tdata[1:0];
  assign slot         = out_tdata[8:2];
  assign quantity     = out_tdata[40:9];
  assign entries_used = out_tdata[48:41];

  // A waiting input transaction keeps its payload until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("input changed while waiting");

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // One transaction at a time: the input closes right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a transaction is in progress");

  // A failed request reports slot 0 and quantity 0.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (status == ST_FULL || status == ST_EXISTS || status == ST_MISSING)
    |-> slot == '0 && quantity == '0)
    else $error("failed request carries a nonzero slot or quantity");

  // A full answer only comes from a table that is really full.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status == ST_FULL |-> entries_used == USED_W'(TABLE_DEPTH))
    else $error("table full reported with entries free");

endmodule : kqt_checker

bind keyed_quantity_table kqt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_kqt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// File: sim/tb_keyed_quantity_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyed_quantity_table: self-checking bench for the keyed quantity table
// Drives insert, search, update and unused requests over the input stream and
// compares every response with a table model kept inside a scoreboard.
// ----------------------------------------------------------------------------
module tb_keyed_quantity_table;
  import kqt_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 600;
  localparam int KEY_POOL_SIZE = 160;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [QTY_W-1:0]    quantity;
    logic [USED_W-1:0]   used;
  } table_resp_t;

  class qty_table_scoreboard;
    logic [KEY_W-1:0] key_mem [TABLE_DEPTH_DEF];
    logic [QTY_W-1:0] qty_mem [TABLE_DEPTH_DEF];
    int unsigned      fill;
    table_resp_t      expected_resp [$];
    int unsigned      errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function bit find_key(logic [KEY_W-1:0] key, output int unsigned where);
      where = 0;
      for (int i = 0; i < fill; i++) begin
        if (key_mem[i] == key) begin
          where = i;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Applies one accepted request to the model table and queues its response.
    function void note_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
                               logic [QTY_W-1:0] amt);
      table_resp_t r;
      int unsigned idx;
      longint      sum;
      longint      qty_max;
      longint      qty_min;
      qty_max = (longint'(1) <<< 31) - 1;
      qty_min = -(longint'(1) <<< 31);
      r = '0;
      case (req)
        REQ_INSERT: begin
          // A full table refuses before the key is looked at.
          if (fill >= TABLE_DEPTH_DEF) begin
            r.status = ST_FULL;
          end else if (find_key(key, idx)) begin
            r.status = ST_EXISTS;
          end else begin
            key_mem[fill] = key;
            qty_mem[fill] = amt;
            r.slot = SLOT_W'(fill);
            r.quantity = amt;
            fill++;
          end
        end
        REQ_SEARCH: begin
          if (find_key(key, idx)) begin
            r.slot = SLOT_W'(idx);
            r.quantity = qty_mem[idx];
          end else begin
            r.status = ST_MISSING;
          end
        end
        REQ_UPDATE: begin
          if (find_key(key, idx)) begin
            sum = longint'($signed(qty_mem[idx])) + longint'($signed(amt));
            if (sum > qty_max) sum = qty_max;
            if (sum < qty_min) sum = qty_min;
            qty_mem[idx] = sum[QTY_W-1:0];
            r.slot = SLOT_W'(idx);
            r.quantity = qty_mem[idx];
          end else begin
            r.status = ST_MISSING;
          end
        end
        default: begin
          // The unused code answers ok with zero slot and quantity.
        end
      endcase
      r.used = USED_W'(fill);
      expected_resp.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_response(logic [OUT_DATA_W-1:0] data);
      table_resp_t exp_r;
      table_resp_t got;
      got.status   = data[STATUS_W-1:0];
      got.slot     = data[STATUS_W +: SLOT_W];
      got.quantity = data[STATUS_W+SLOT_W +: QTY_W];
      got.used     = data[STATUS_W+SLOT_W+QTY_W +: USED_W];
      if (expected_resp.size() == 0) begin
        report_mismatch($sformatf("response %h with no request pending", data));
      end else begin
        exp_r = expected_resp.pop_front();
        if (got.status !== exp_r.status)
          report_mismatch($sformatf("status exp %0d got %0d", exp_r.status, got.status));
        if (got.slot !== exp_r.slot)
          report_mismatch($sformatf("slot exp %0d got %0d", exp_r.slot, got.slot));
        if (got.quantity !== exp_r.quantity)
          report_mismatch($sformatf("quantity exp %h got %h", exp_r.quantity,
                                    got.quantity));
        if (got.used !== exp_r.used)
          report_mismatch($sformatf("entries_used exp %0d got %0d", exp_r.used,
                                    got.used));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;   // [31:0] part_key, [63:32] amount
  logic [REQ_W-1:0] in_tuser = '0;       // [1:0] req_type
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;      // [1:0] status, [8:2] slot,
                                         // [40:9] quantity, [48:41] entries_used

  qty_table_scoreboard sb;
  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];
  logic [QTY_W-1:0] extreme_val [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  keyed_quantity_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet) return 0;
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic offer_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
                               logic [QTY_W-1:0] amt);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {amt, key};
    in_tuser  <= req;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Both handshakes are sampled here, on values settled before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_request(in_tuser, in_tdata[KEY_W-1:0], in_tdata[IN_DATA_W-1:KEY_W]);
      if (out_tvalid && out_tready)
        sb.check_response(out_tdata);
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin : receiver
    int unsigned stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [REQ_W-1:0] req;
    logic [KEY_W-1:0] key;
    logic [QTY_W-1:0] amt;
    int unsigned roll;
    int unsigned sel;
    int unsigned fresh_ptr;
    sb = new();
    fresh_ptr = 0;
    // Half of the pool are small keys near zero, half are wide random keys.
    for (int i = 0; i < KEY_POOL_SIZE; i++)
      key_pool[i] = (i % 2) ? $urandom() : 32'(i) - 32'd40;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Lookups on an empty table, and the unused code.
    offer_request(REQ_SEARCH, 32'h0, 32'h0);
    offer_request(REQ_UPDATE, 32'h0, 32'h1);
    offer_request(REQ_UNUSED, 32'h0, 32'h0);
    // Extreme keys and quantities.
    offer_request(REQ_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
    offer_request(REQ_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
    offer_request(REQ_INSERT, 32'h0, 32'h0);
    offer_request(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_request(REQ_INSERT, 32'h0, 32'h1234_5678);
    offer_request(REQ_SEARCH, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    // Saturation at both ends, sums that stay in range, a repeated low saturation and a missing key.
    offer_request(REQ_UPDATE, 32'h8000_0000, 32'h0000_0001);
    offer_request(REQ_UPDATE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    offer_request(REQ_UPDATE, 32'h8000_0000, 32'h8000_0000);
    offer_request(REQ_UPDATE, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    offer_request(REQ_UPDATE, 32'h0, 32'h8000_0000);
    offer_request(REQ_UPDATE, 32'h0, 32'h8000_0000);
    offer_request(REQ_SEARCH, 32'hFFFF_FFFF, 32'h0);
    offer_request(REQ_SEARCH, 32'h0000_3039, 32'h0);
    offer_request(REQ_UPDATE, 32'h0000_3039, 32'h7FFF_FFFF);
    offer_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Inserts mostly take fresh pool keys so the table fills and then overflows.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = ((n / 100) == 2);
      if (n == 300) hold_request = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 45)      req = REQ_INSERT;
      else if (roll < 70) req = REQ_SEARCH;
      else if (roll < 97) req = REQ_UPDATE;
      else                req = REQ_UNUSED;
      sel = $urandom_range(0, 99);
      if (req == REQ_INSERT) begin
        if (sel < 70) begin
          key = key_pool[fresh_ptr % KEY_POOL_SIZE];
          fresh_ptr++;
        end else if (sel < 90) begin
          key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        end else begin
          key = $urandom();
        end
      end else begin
        if (sel < 80)      key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        else if (sel < 90) key = extreme_val[$urandom_range(0, 3)];
        else               key = $urandom();
      end
      sel = $urandom_range(0, 99);
      if (sel < 20)      amt = extreme_val[$urandom_range(0, 3)];
      else if (sel < 60) amt = int'($urandom_range(0, 2000)) - 1000;
      else               amt = $urandom();
      offer_request(req, key, amt);
    end
    in_tvalid <= 1'b0;
    quiet = 1'b0;

    @(posedge clk);
    while (sb.expected_resp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
